// File: rtl/core/assert_macros.svh
// Assertion macros shared by the downscaler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check a condition in the cycle after a trigger.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/bbd_pkg.sv
// Shared constants and types for the bilevel box downscaler.
package bbd_pkg;

  localparam int unsigned MAX_WIDTH     = 8192;
  localparam int unsigned BLOCK_COLUMNS = 17;
  localparam int unsigned BLOCK_ROWS    = 15;

  localparam int unsigned CFG_WIDTH_W  = 14;
  localparam int unsigned CFG_HEIGHT_W = 16;
  localparam int unsigned CFG_DATA_W   = 16;

  localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RESET  = CFG_WIDTH_W'(17);
  localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RESET = CFG_HEIGHT_W'(15);

  localparam logic CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic CFG_IMAGE_HEIGHT = 1'b1;

  localparam int unsigned PIX_W   = 8;
  localparam int unsigned CNT_W   = 4;
  localparam int unsigned WORD_W  = PIX_W * CNT_W;
  localparam int unsigned GRAY_W  = 8;
  localparam int unsigned RUN_W   = 5;
  localparam int unsigned BAND_W  = 4;

  localparam int unsigned OUT_FIFO_DEPTH = 4;
  localparam int unsigned OUT_PTR_W      = $clog2(OUT_FIFO_DEPTH);
  localparam int unsigned OUT_CNT_W      = $clog2(OUT_FIFO_DEPTH + 1);

  typedef struct packed {
    logic [GRAY_W-1:0] gray_level;
    logic              last_in_row;
    logic              last_of_image;
  } result_t;

  typedef struct packed {
    logic [OUT_CNT_W-1:0] count;
    logic                 empty;
  } fifo_status_t;

endpackage

// File: rtl/core/bilevel_box_downscale_17x15_unit.sv
// Bilevel-to-gray box downscaler: each input item is one byte of eight
// packed pixels (bit 7 leftmost); a line store keeps per-column set-pixel
// counts over each band of 15 rows, and while the last row of a band streams
// in, every complete run of 17 columns yields one 8-bit gray item. One byte
// is taken every clock cycle; the byte that completes a run is registered into
// stage 1, which pushes its gray item into the result queue. The rate is set
// by the line store, one read and one write per cycle, with the written word
// forwarded when the next byte hits the same entry (rows of one byte). Input
// stalls only when the four-entry result queue backs up. The line store needs
// no clearing: the first row of each band overwrites its entries. Writing
// image_width or image_height restarts the image.
`include "assert_macros.svh"
module bilevel_box_downscale_17x15_unit #(
  parameter int unsigned MaxWidth = bbd_pkg::MAX_WIDTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic                              cfg_idx_i,
  input  logic [bbd_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [bbd_pkg::PIX_W-1:0]         pixel_byte_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [bbd_pkg::GRAY_W-1:0]        gray_level_o,
  output logic                              last_in_row_o,
  output logic                              last_of_image_o
);

  localparam int unsigned Depth    = MaxWidth / 8;
  localparam int unsigned RowBytes = (MaxWidth + 7) / 8;
  localparam int unsigned AW       = $clog2(Depth);
  localparam int unsigned BW       = $clog2(RowBytes);
  localparam int unsigned CW       = BW + 3;
  localparam int unsigned WW       = CW + 1;
  localparam int unsigned LW       = 17;

  localparam logic [bbd_pkg::BAND_W-1:0] LastBand =
    bbd_pkg::BAND_W'(bbd_pkg::BLOCK_ROWS - 1);

  logic [bbd_pkg::CFG_WIDTH_W-1:0]  width_q;
  logic [bbd_pkg::CFG_HEIGHT_W-1:0] height_q;

  logic [BW-1:0]                    byte_q, byte_d;
  logic [bbd_pkg::BAND_W-1:0]       band_q, band_d;
  logic [bbd_pkg::CFG_HEIGHT_W-1:0] row_q, row_d;
  logic [bbd_pkg::GRAY_W-1:0]       run_sum_q, run_sum_d;
  logic [bbd_pkg::RUN_W-1:0]        column_in_run_q, column_in_run_d;

  logic                             s1_valid_q;
  logic [BW-1:0]                    s1_byte_q;
  logic [bbd_pkg::PIX_W-1:0]        s1_pix_q;
  logic                             s1_first_q;
  logic                             s1_wr_q;
  logic                             s1_last_row_q;
  logic                             s1_row_end_q;
  logic                             s1_last_band_q;
  logic                             s1_fwd_q;
  logic [bbd_pkg::WORD_W-1:0]       s1_fwd_word_q;

  logic [LW-1:0]                    width_ext;
  logic [LW-1:0]                    width_clamp;
  logic [WW-1:0]                    w;
  logic [WW:0]                      w_plus;
  logic [WW-3:0]                    bpr_raw;
  logic [WW-3:0]                    bpr;
  logic [WW-3:0]                    byte_next;
  logic                             row_end;
  logic [LW-1:0]                    band_start;
  logic                             active;
  logic                             in_store;
  logic                             last_band;
  logic [LW-1:0]                    row_next;
  logic                             in_fire;
  logic                             fwd_hit;

  logic [bbd_pkg::WORD_W-1:0]       rd_word;
  logic [bbd_pkg::WORD_W-1:0]       old_word;
  logic [bbd_pkg::WORD_W-1:0]       new_word;
  logic                             emit;
  bbd_pkg::result_t                 emit_res;
  logic [bbd_pkg::GRAY_W-1:0]       sum_c;
  logic [bbd_pkg::RUN_W-1:0]        cir_c;

  bbd_pkg::result_t                 head;
  bbd_pkg::fifo_status_t            fifo_st;
  logic                             pop;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= bbd_pkg::WIDTH_RESET;
      height_q <= bbd_pkg::HEIGHT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bbd_pkg::CFG_IMAGE_WIDTH:  width_q  <= cfg_data_i[bbd_pkg::CFG_WIDTH_W-1:0];
        bbd_pkg::CFG_IMAGE_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // stage 0: position tracking and line store read
  always_comb begin
    width_ext   = LW'(width_q);
    width_clamp = (width_ext > LW'(MaxWidth)) ? LW'(MaxWidth) : width_ext;
    w           = width_clamp[WW-1:0];
    w_plus      = {1'b0, w} + (WW+1)'(7);
    bpr_raw     = w_plus[WW:3];
    bpr         = (bpr_raw == '0) ? (WW-2)'(1) : bpr_raw;
    byte_next   = (WW-2)'(byte_q) + (WW-2)'(1);
    row_end     = (byte_next >= bpr);
    band_start  = LW'(row_q) - LW'(band_q);
    active      = (band_start + LW'(bbd_pkg::BLOCK_ROWS)) <= LW'(height_q);
    in_store    = (LW'(byte_q) < LW'(Depth));
    last_band   = (LW'(row_q) + LW'(bbd_pkg::BLOCK_ROWS + 1)) > LW'(height_q);
    row_next    = LW'(row_q) + LW'(1);
  end

  assign in_ready_o = (LW'(fifo_st.count) + LW'(s1_valid_q)) < LW'(bbd_pkg::OUT_FIFO_DEPTH);
  assign in_fire    = in_valid_i && in_ready_o;
  assign fwd_hit    = s1_valid_q && s1_wr_q && (s1_byte_q[AW-1:0] == byte_q[AW-1:0]);

  always_comb begin
    byte_d = byte_q;
    band_d = band_q;
    row_d  = row_q;
    if (in_fire) begin
      if (row_end) begin
        byte_d = '0;
        if (active) begin
          band_d = (band_q == LastBand) ? '0 : band_q + bbd_pkg::BAND_W'(1);
        end else begin
          band_d = '0;
        end
        if (row_next >= LW'(height_q)) begin
          row_d  = '0;
          band_d = '0;
        end else begin
          row_d = row_next[bbd_pkg::CFG_HEIGHT_W-1:0];
        end
      end else begin
        byte_d = byte_next[BW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q     <= '0;
      band_q     <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_fire;
      if (cfg_we_i) begin
        byte_q <= '0;
        band_q <= '0;
        row_q  <= '0;
      end else begin
        byte_q <= byte_d;
        band_q <= band_d;
        row_q  <= row_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_byte_q      <= byte_q;
      s1_pix_q       <= pixel_byte_i;
      s1_first_q     <= (band_q == '0);
      s1_wr_q        <= active && in_store;
      s1_last_row_q  <= active && in_store && (band_q == LastBand);
      s1_row_end_q   <= row_end;
      s1_last_band_q <= last_band;
      s1_fwd_q       <= fwd_hit;
      s1_fwd_word_q  <= new_word;
    end
  end

  bbd_line_store #(
    .Depth (Depth),
    .AddrW (AW)
  ) u_line_store (
    .clk_i     (clk_i),
    .rd_en_i   (in_fire),
    .rd_addr_i (byte_q[AW-1:0]),
    .rd_data_o (rd_word),
    .wr_en_i   (s1_valid_q && s1_wr_q),
    .wr_addr_i (s1_byte_q[AW-1:0]),
    .wr_data_i (new_word)
  );

  // stage 1: add the byte into the column counts and sum runs
  always_comb begin
    logic [bbd_pkg::CNT_W-1:0] cnt;
    logic [CW-1:0]             col;
    logic                      in_w;
    logic                      pix;
    old_word = s1_fwd_q ? s1_fwd_word_q : rd_word;
    new_word = '0;
    sum_c    = run_sum_q;
    cir_c    = column_in_run_q;
    emit     = 1'b0;
    emit_res = '0;
    for (int k = 0; k < bbd_pkg::PIX_W; k++) begin
      col  = {s1_byte_q, 3'(k)};
      in_w = ({1'b0, col} < w);
      pix  = in_w && s1_pix_q[bbd_pkg::PIX_W-1-k];
      cnt  = s1_first_q ? '0 : old_word[bbd_pkg::CNT_W*k +: bbd_pkg::CNT_W];
      cnt  = cnt + bbd_pkg::CNT_W'(pix);
      new_word[bbd_pkg::CNT_W*k +: bbd_pkg::CNT_W] = cnt;
      if (s1_last_row_q && in_w) begin
        sum_c = sum_c + bbd_pkg::GRAY_W'(cnt);
        cir_c = cir_c + bbd_pkg::RUN_W'(1);
        if (cir_c == bbd_pkg::RUN_W'(bbd_pkg::BLOCK_COLUMNS)) begin
          emit                   = 1'b1;
          emit_res.gray_level    = sum_c;
          emit_res.last_in_row   =
            ({1'b0, col} + WW'(bbd_pkg::BLOCK_COLUMNS + 1)) > w;
          emit_res.last_of_image = emit_res.last_in_row && s1_last_band_q;
          sum_c                  = '0;
          cir_c                  = '0;
        end
      end
    end
  end

  always_comb begin
    run_sum_d       = run_sum_q;
    column_in_run_d = column_in_run_q;
    if (s1_valid_q) begin
      if (s1_row_end_q) begin
        run_sum_d       = '0;
        column_in_run_d = '0;
      end else begin
        run_sum_d       = sum_c;
        column_in_run_d = cir_c;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_sum_q       <= '0;
      column_in_run_q <= '0;
    end else if (cfg_we_i) begin
      run_sum_q       <= '0;
      column_in_run_q <= '0;
    end else begin
      run_sum_q       <= run_sum_d;
      column_in_run_q <= column_in_run_d;
    end
  end

  // result queue
  assign pop = out_valid_o && out_ready_i;

  bbd_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s1_valid_q && emit),
    .push_data_i (emit_res),
    .pop_i       (pop),
    .head_o      (head),
    .status_o    (fifo_st)
  );

  assign out_valid_o     = !fifo_st.empty;
  assign gray_level_o    = head.gray_level;
  assign last_in_row_o   = head.last_in_row;
  assign last_of_image_o = head.last_of_image;

  `ASSERT_ALWAYS(a_queue_bound, clk_i, rst_ni,
    (LW'(fifo_st.count) <= LW'(bbd_pkg::OUT_FIFO_DEPTH)), "result queue overflow")
  `ASSERT_ALWAYS(a_run_bound, clk_i, rst_ni,
    (column_in_run_q < bbd_pkg::RUN_W'(bbd_pkg::BLOCK_COLUMNS)), "run counter past run length")
  `ASSERT_ALWAYS(a_image_implies_row, clk_i, rst_ni,
    (!out_valid_o || !last_of_image_o || last_in_row_o), "image end not at row end")
  `ASSERT_NEXT(a_row_wrap, clk_i, rst_ni, (in_fire && row_end),
    (byte_q == '0), "byte position not cleared at row end")

endmodule

// File: rtl/core/bbd_line_store.sv
// Column count line store: one registered read port and one write port.
module bbd_line_store #(
  parameter int unsigned Depth = bbd_pkg::MAX_WIDTH / 8,
  parameter int unsigned AddrW = $clog2(bbd_pkg::MAX_WIDTH / 8)
) (
  input  logic                        clk_i,
  input  logic                        rd_en_i,
  input  logic [AddrW-1:0]            rd_addr_i,
  output logic [bbd_pkg::WORD_W-1:0]  rd_data_o,
  input  logic                        wr_en_i,
  input  logic [AddrW-1:0]            wr_addr_i,
  input  logic [bbd_pkg::WORD_W-1:0]  wr_data_i
);

  logic [bbd_pkg::WORD_W-1:0] mem [Depth];
  logic [bbd_pkg::WORD_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: rtl/core/bbd_out_fifo.sv
// Small result queue between the count pipeline and the output channel.
module bbd_out_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  bbd_pkg::result_t      push_data_i,
  input  logic                  pop_i,
  output bbd_pkg::result_t      head_o,
  output bbd_pkg::fifo_status_t status_o
);

  bbd_pkg::result_t                  slot_q [bbd_pkg::OUT_FIFO_DEPTH];
  logic [bbd_pkg::OUT_PTR_W-1:0]     wr_ptr_q, wr_ptr_d;
  logic [bbd_pkg::OUT_PTR_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [bbd_pkg::OUT_CNT_W-1:0]     count_q, count_d;
  logic                              do_pop;

  assign do_pop = pop_i && (count_q != '0);

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + bbd_pkg::OUT_PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + bbd_pkg::OUT_PTR_W'(1) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !do_pop) begin
      count_d = count_q + bbd_pkg::OUT_CNT_W'(1);
    end else if (!push_i && do_pop) begin
      count_d = count_q - bbd_pkg::OUT_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign head_o         = slot_q[rd_ptr_q];
  assign status_o.count = count_q;
  assign status_o.empty = (count_q == '0);

endmodule
